// ===== design/tsfp_pkg.sv =====
package tsfp_pkg;

   // queue between parser front and output back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // payload lengths per packet type
   localparam logic [7:0] BLOCK_REQ_LEN = 8'd16;
   localparam logic [7:0] DATA_REQ_LEN  = 8'd32;
   localparam logic [7:0] XFER_DONE_LEN = 8'd16;

   // result event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_ACK      = 3'd1;
   localparam logic [2:0] EV_NOK      = 3'd2;
   localparam logic [2:0] EV_NOQ      = 3'd3;
   localparam logic [2:0] EV_PKT_TAG  = 3'd4;
   localparam logic [2:0] EV_PAYLOAD  = 3'd5;
   localparam logic [2:0] EV_VER_DONE = 3'd6;

   // packet types
   localparam logic [1:0] PT_BLOCK_REQ = 2'd0;
   localparam logic [1:0] PT_DATA_REQ  = 2'd1;

   // tag indexes
   localparam logic [2:0] TAG_ACK = 3'd0;
   localparam logic [2:0] TAG_NOK = 3'd1;
   localparam logic [2:0] TAG_NOQ = 3'd2;
   localparam logic [2:0] TAG_VER = 3'd3;
   localparam logic [2:0] TAG_RQB = 3'd4;
   localparam logic [2:0] TAG_ADR = 3'd5;
   localparam logic [2:0] TAG_XFC = 3'd6;
   localparam logic [2:0] TAG_XTO = 3'd7;
   localparam int unsigned NUM_TAGS = 8;

   // tag text, oldest character in the top byte
   localparam logic [31:0] TAG_TEXT [NUM_TAGS] = '{
      32'h41434B3E,   // ACK>
      32'h4E4F4B3E,   // NOK>
      32'h4E4F513E,   // NOQ>
      32'h5645523E,   // VER>
      32'h5251423E,   // RQB>
      32'h4144523E,   // ADR>
      32'h5846433E,   // XFC>
      32'h58544F3E    // XTO>
   };

   // one classified beat handed from front to back
   typedef struct packed {
      logic [2:0]  ev;
      logic [1:0]  ptype;
      logic [7:0]  pbyte;
      logic [7:0]  pidx;
      logic        plast;
      logic [31:0] ver_chars;
   } entry_type;

   // payload length of a type, zero acts as one
   function automatic logic [7:0] payload_len(input logic [1:0] ptype);
      logic [7:0] n;
      begin
         if (ptype == PT_BLOCK_REQ) n = BLOCK_REQ_LEN;
         else if (ptype == PT_DATA_REQ) n = DATA_REQ_LEN;
         else n = XFER_DONE_LEN;
         payload_len = (n == 8'd0) ? 8'd1 : n;
      end
   endfunction

   // leading hex digits of four characters, stops at first non-hex
   function automatic logic [15:0] parse_version(input logic [31:0] chars);
      logic [15:0] v;
      logic        stop;
      logic [7:0]  c;
      logic [3:0]  d;
      logic        ok;
      begin
         v    = 16'd0;
         stop = 1'b0;
         for (int i = 0; i < 4; i++) begin
            c  = chars[31 - 8*i -: 8];
            ok = 1'b1;
            d  = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
            else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
            else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
            else ok = 1'b0;
            if (!ok) stop = 1'b1;
            if (!stop) v = {v[11:0], d};
         end
         parse_version = v;
      end
   endfunction

endpackage

// ===== design/tsfp_front.sv =====
module tsfp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [7:0]           rx_byte,
   output tsfp_pkg::entry_type  push_data
);

   typedef enum logic [2:0] {
      MODE_HUNT    = 3'b001,
      MODE_VER     = 3'b010,
      MODE_PAYLOAD = 3'b100
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] window_ff, window_in;
   logic [7:0]  count_ff, count_in;
   logic [1:0]  type_ff, type_in;
   logic [31:0] shifted;
   logic        hit;
   logic [2:0]  hit_idx;

   // tag compare on the shifted window
   always_comb begin
      shifted = {window_ff[23:0], rx_byte};
      hit     = 1'b0;
      hit_idx = tsfp_pkg::TAG_ACK;
      for (int t = tsfp_pkg::NUM_TAGS - 1; t >= 0; t--) begin
         if (shifted == tsfp_pkg::TAG_TEXT[t]) begin
            hit     = 1'b1;
            hit_idx = 3'(t);
         end
      end
   end

   // parser next state and classified beat
   always_comb begin
      mode_in   = mode_ff;
      window_in = window_ff;
      count_in  = count_ff;
      type_in   = type_ff;
      push_data = '0;
      unique case (mode_ff)
         MODE_PAYLOAD: begin
            push_data.ev    = tsfp_pkg::EV_PAYLOAD;
            push_data.ptype = type_ff;
            push_data.pbyte = rx_byte;
            push_data.pidx  = count_ff;
            if (({1'b0, count_ff} + 9'd1) >= {1'b0, tsfp_pkg::payload_len(type_ff)}) begin
               push_data.plast = 1'b1;
               mode_in         = MODE_HUNT;
               count_in        = 8'd0;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
         MODE_VER: begin
            case (count_ff[1:0])
               2'd0:    window_in[31:24] = rx_byte;
               2'd1:    window_in[23:16] = rx_byte;
               2'd2:    window_in[15:8]  = rx_byte;
               default: window_in[7:0]   = rx_byte;
            endcase
            count_in            = count_ff + 8'd1;
            push_data.ver_chars = window_in;
            if (count_ff >= 8'd3) begin
               push_data.ev = tsfp_pkg::EV_VER_DONE;
               mode_in      = MODE_HUNT;
               count_in     = 8'd0;
            end
         end
         default: begin
            mode_in   = MODE_HUNT;
            window_in = shifted;
            if (hit) begin
               window_in = '0;
               count_in  = 8'd0;
               if (hit_idx <= tsfp_pkg::TAG_NOQ) begin
                  push_data.ev = hit_idx + 3'd1;
               end else if (hit_idx == tsfp_pkg::TAG_VER) begin
                  mode_in = MODE_VER;
               end else begin
                  type_in         = hit_idx[1:0];
                  mode_in         = MODE_PAYLOAD;
                  push_data.ev    = tsfp_pkg::EV_PKT_TAG;
                  push_data.ptype = hit_idx[1:0];
               end
            end
         end
      endcase
   end

   // parser state, advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HUNT;
         window_ff <= '0;
         count_ff  <= 8'd0;
         type_ff   <= 2'd0;
      end else if (push) begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         type_ff   <= type_in;
      end
   end

   // last payload beat returns to hunting
   a_last_to_hunt: assert property (@(posedge clock) disable iff (reset)
      push && push_data.plast |=> mode_ff == MODE_HUNT && count_ff == 8'd0)
      else $error("payload end did not return to hunting");

   // version field never runs past four characters
   a_ver_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_VER |-> count_ff < 8'd4)
      else $error("version count out of range");

   // payload index stays below the packet length
   a_payload_idx: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAYLOAD |-> count_ff < tsfp_pkg::payload_len(type_ff))
      else $error("payload index beyond packet length");

endmodule

// ===== design/tsfp_queue.sv =====
module tsfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsfp_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output tsfp_pkg::entry_type  pop_data,
   output logic                 not_empty
);

   tsfp_pkg::entry_type              slot_ff [tsfp_pkg::QUEUE_DEPTH];
   logic [tsfp_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [tsfp_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == tsfp_pkg::QCNT_W'(tsfp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/tsfp_back.sv =====
module tsfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tsfp_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [4:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   typedef struct packed {
      logic [2:0]  ev;
      logic [1:0]  ptype;
      logic [7:0]  pbyte;
      logic [7:0]  pidx;
      logic        plast;
      logic [15:0] version;
   } rsp_type;

   rsp_type     out_ff;
   logic        out_valid_ff;
   logic [15:0] version_ff, version_in;

   // take the next beat when the output register is free or draining
   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   // version register follows completed version fields
   always_comb begin
      version_in = version_ff;
      if (head.ev == tsfp_pkg::EV_VER_DONE) version_in = tsfp_pkg::parse_version(head.ver_chars);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         version_ff   <= 16'd0;
      end else begin
         if (pop) begin
            out_valid_ff <= 1'b1;
            version_ff   <= version_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff.ev      <= head.ev;
         out_ff.ptype   <= head.ptype;
         out_ff.pbyte   <= head.pbyte;
         out_ff.pidx    <= head.pidx;
         out_ff.plast   <= head.plast;
         out_ff.version <= version_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.version, out_ff.pidx, out_ff.pbyte};
   assign rsp_tuser  = {out_ff.ptype, out_ff.ev};
   assign rsp_tlast  = out_ff.plast;

   // last mark only on payload beats
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.plast |-> out_ff.ev == tsfp_pkg::EV_PAYLOAD)
      else $error("last mark on a non-payload beat");

   // shown version matches the held version register
   a_version_held: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_ff.version == version_ff)
      else $error("output version differs from version register");

   // packet type is zero outside packet events
   a_ptype_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.ev != tsfp_pkg::EV_PAYLOAD && out_ff.ev != tsfp_pkg::EV_PKT_TAG
      |-> out_ff.ptype == 2'd0)
      else $error("packet type set on a non-packet beat");

endmodule

// ===== design/tagged_serial_frame_parser.sv =====
// Tagged serial frame parser.
// The req channel takes one received serial byte per beat. The rsp channel
// gives exactly one result beat for every byte accepted, in order: an event
// code with packet type in tuser, payload byte, payload index and the last
// parsed version in tdata, and tlast on the final payload byte of a packet.
// A hunting front slides a four-byte window over the bytes and matches reply,
// version and packet tags; it tracks version and payload fields and pushes a
// classified beat into a four-entry queue. The back decodes version digits,
// holds the version register and drives a registered output stage.
// Throughput is one byte per cycle while the queue is not full. An accepted
// byte is written into the queue and then into the output register for rsp.
// When rsp_tready is low the output register holds its beat, the queue fills
// and req_tready drops once the queue holds four beats.
// Synchronous reset returns to hunting with a cleared window, payload count
// and packet type, a zero version and an empty queue; no clearing pass.
module tagged_serial_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] payload_byte, [15:8] payload_index,
                                     // [31:16] version_value
   output logic [4:0]  rsp_tuser,    // [2:0] event_res, [4:3] packet_type
   output logic        rsp_tlast     // last_of_packet
);

   tsfp_pkg::entry_type push_data, head;
   logic                push, full, pop, head_valid;

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   tsfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rx_byte   (req_tdata),
      .push_data (push_data)
   );

   tsfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (head),
      .not_empty (head_valid)
   );

   tsfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
